>>> rtl/core/srs_pkg.sv
// Shared types, constants and pin helpers for the region selector.
`default_nettype none

package srs_pkg;

    // Region codes
    localparam logic [1:0] REGION_JP = 2'd0;
    localparam logic [1:0] REGION_EU = 2'd1;
    localparam logic [1:0] REGION_US = 2'd2;
    localparam logic [1:0] LED_NONE  = 2'd3;

    // Fixed timing constants
    localparam logic [2:0] DEBOUNCE_TICKS = 3'd5;
    localparam logic [7:0] CONFIRM_LIMIT  = 8'd5;

    // Pin latch bit positions
    localparam int PB_RED     = 0;
    localparam int PB_GREEN   = 1;
    localparam int PB_BLUE    = 2;
    localparam int PB_VIDEO   = 3;
    localparam int PB_LANG    = 4;
    localparam int PB_VIDEO_N = 5;
    localparam int PB_LANG_N  = 6;
    localparam int PB_RESET_N = 7;

    localparam logic [7:0] PIN_RESET_INIT = 8'h80;

    // Configuration register indexes
    localparam logic [2:0] CFG_MCD_MODE         = 3'd0;
    localparam logic [2:0] CFG_LED_COMMON_ANODE = 3'd1;
    localparam logic [2:0] CFG_HOME_REGION      = 3'd2;
    localparam logic [2:0] CFG_CHANGE_TICKS     = 3'd3;
    localparam logic [2:0] CFG_FAST_BLINK_TICKS = 3'd4;
    localparam logic [2:0] CFG_SLOW_BLINK_TICKS = 3'd5;
    localparam logic [2:0] CFG_TURN_LIMIT       = 3'd6;
    localparam logic [2:0] CFG_RESET_TICKS      = 3'd7;

    // Configuration reset values
    localparam logic       RST_MCD_MODE         = 1'b0;
    localparam logic       RST_LED_COMMON_ANODE = 1'b1;
    localparam logic [1:0] RST_HOME_REGION      = 2'd1;
    localparam logic [9:0] RST_CHANGE_TICKS     = 10'd200;
    localparam logic [7:0] RST_FAST_BLINK_TICKS = 8'd16;
    localparam logic [7:0] RST_SLOW_BLINK_TICKS = 8'd33;
    localparam logic [7:0] RST_TURN_LIMIT       = 8'd8;
    localparam logic [7:0] RST_RESET_TICKS      = 8'd33;

    typedef struct packed {
        logic       mcd_mode;
        logic       led_common_anode;
        logic [1:0] home_region;
        logic [9:0] change_ticks;
        logic [7:0] fast_blink_ticks;
        logic [7:0] slow_blink_ticks;
        logic [7:0] turn_limit;
        logic [7:0] reset_ticks;
    } cfg_t;

    typedef struct packed {
        logic       started;
        logic [1:0] region_now;
        logic       edge_pending;
        logic       press_active;
        logic       showing;
        logic       confirming;
        logic       reset_active;
        logic       blink_phase;
        logic [7:0] turn_count;
        logic [7:0] wait_count;
        logic [2:0] debounce_count;
        logic [7:0] pin_latch;
    } state_t;

    // Selector state after reset: idle, home region code, reset pin high
    localparam state_t STATE_RESET = {1'b0, RST_HOME_REGION, 6'd0, 8'd0, 8'd0, 3'd0,
                                      PIN_RESET_INIT};

    // Drive the three LED bits for one region code, or all off
    function automatic logic [7:0] show_led(input logic [7:0] pin, input logic [1:0] code,
                                            input logic common_anode);
        logic [2:0] on;
        logic [2:0] led;
        case (code)
            REGION_JP: on = 3'b001;
            REGION_EU: on = 3'b010;
            REGION_US: on = 3'b100;
            default:   on = 3'b000;
        endcase
        led = common_anode ? ~on : on;
        return {pin[7:3], led};
    endfunction

    // Video, language and their inverse for one region
    function automatic logic [7:0] region_pins(input logic [7:0] pin,
                                               input logic [1:0] region);
        logic [3:0] bits;  // lang_n, video_n, lang, video
        case (region)
            REGION_JP: bits = 4'b1001;
            REGION_EU: bits = 4'b0110;
            default:   bits = 4'b0011;
        endcase
        return {pin[7], bits, pin[2:0]};
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/srs_step.sv
// Next-state logic for one poll pass of the region selector.
`default_nettype none

module srs_step
    import srs_pkg::*;
#(
    parameter int HOLD_WIDTH = 16
) (
    input  cfg_t                  cfg,
    input  state_t                st,
    input  logic [HOLD_WIDTH-1:0] hold,
    input  logic                  tick,
    input  logic                  button_edge,
    input  logic                  button_down,
    output state_t                st_next,
    output logic [HOLD_WIDTH-1:0] hold_next
);

    always_comb
    begin
        state_t                s;
        logic [HOLD_WIDTH-1:0] h;
        logic                  long_hold;

        s = st;
        h = hold;

        // First pass: form start state from current registers
        if (!s.started)
        begin
            s.region_now   = (cfg.home_region > REGION_US) ? REGION_US : cfg.home_region;
            s.pin_latch    = region_pins(PIN_RESET_INIT, s.region_now);
            s.reset_active = 1'b0;
            s.wait_count   = 8'd0;
            if (cfg.mcd_mode)
            begin
                s.pin_latch[PB_RESET_N] = 1'b0;
                s.reset_active          = 1'b1;
                s.wait_count            = cfg.reset_ticks;
            end
            s.pin_latch = show_led(s.pin_latch, s.region_now, cfg.led_common_anode);
            s.started   = 1'b1;
        end

        // Debounce: take a pending edge once the counter is idle
        if (button_edge)
            s.edge_pending = 1'b1;
        if (s.edge_pending && s.debounce_count == 3'd0)
        begin
            s.debounce_count = DEBOUNCE_TICKS;
            s.press_active   = 1'b1;
            s.edge_pending   = 1'b0;
        end

        // Timer tick
        if (tick)
        begin
            if (s.press_active && h != {HOLD_WIDTH{1'b1}})
                h = h + 1'b1;
            if (s.debounce_count != 3'd0)
                s.debounce_count = s.debounce_count - 3'd1;
            if (s.wait_count != 8'd0)
                s.wait_count = s.wait_count - 8'd1;
        end

        long_hold = h > HOLD_WIDTH'(cfg.change_ticks);

        // Press evaluation once debounce expired
        if (s.press_active && s.debounce_count == 3'd0)
        begin
            if (button_down)
            begin
                if (long_hold)
                    s.showing = 1'b1;
            end
            else
            begin
                s.press_active = 1'b0;
                if (long_hold)
                begin
                    s.turn_count = 8'd0;
                    s.showing    = 1'b0;
                    s.confirming = 1'b1;
                end
                else
                begin
                    s.reset_active = 1'b1;
                    s.wait_count   = cfg.reset_ticks;
                end
                h = '0;
            end
        end

        // Fast blink through the regions
        if (s.showing && s.wait_count == 8'd0)
        begin
            s.pin_latch = show_led(s.pin_latch, s.blink_phase ? s.region_now : LED_NONE,
                                   cfg.led_common_anode);
            if (s.turn_count > cfg.turn_limit)
            begin
                s.region_now = (s.region_now == REGION_US) ? REGION_JP : s.region_now + 2'd1;
                s.turn_count = 8'd0;
            end
            else
                s.turn_count = s.turn_count + 8'd1;
            s.blink_phase = !s.blink_phase;
            s.wait_count  = cfg.fast_blink_ticks;
        end

        // Slow confirmation blinks, then apply the region
        if (s.confirming && s.wait_count == 8'd0)
        begin
            s.pin_latch = show_led(s.pin_latch, s.blink_phase ? s.region_now : LED_NONE,
                                   cfg.led_common_anode);
            if (s.turn_count > CONFIRM_LIMIT)
            begin
                s.turn_count = 8'd0;
                s.confirming = 1'b0;
                s.pin_latch  = show_led(s.pin_latch, s.region_now, cfg.led_common_anode);
                s.pin_latch  = region_pins(s.pin_latch, s.region_now);
                if (cfg.mcd_mode)
                begin
                    s.pin_latch[PB_RESET_N] = 1'b0;
                    s.reset_active          = 1'b1;
                    s.wait_count            = cfg.reset_ticks;
                end
            end
            else
                s.turn_count = s.turn_count + 8'd1;
            s.blink_phase = !s.blink_phase;
            s.wait_count  = cfg.slow_blink_ticks;
        end

        // Console reset pulse
        if (s.reset_active)
        begin
            if (s.wait_count != 8'd0)
                s.pin_latch[PB_RESET_N] = 1'b0;
            else
            begin
                s.pin_latch[PB_RESET_N] = 1'b1;
                s.reset_active          = 1'b0;
            end
        end

        st_next   = s;
        hold_next = h;
    end

endmodule

`default_nettype wire

>>> rtl/core/switchless_region_selector.sv
// Result: a result is registered and valid in the cycle after its poll request is accepted.
// Throughput: one request per cycle while the result is taken (m_tready high); the
// output register lets a new request in while a result is taken in the same cycle.
// Reset: rst_n clears control state and loads configuration defaults; the start
// state is formed from the configuration at the first accepted request.
`default_nettype none

module switchless_region_selector
    import srs_pkg::*;
#(
    parameter int HOLD_WIDTH = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Poll request: [0] tick, [1] button_edge, [2] button_down
    input  wire logic        s_tvalid,
    output      logic        s_tready,
    input  wire logic [7:0]  s_tdata,
    // Result: [0] led_red, [1] led_green, [2] led_blue, [3] video_pin,
    // [4] language_pin, [5] video_pin_n, [6] language_pin_n, [7] reset_out_n,
    // [9:8] current_region
    output      logic        m_tvalid,
    input  wire logic        m_tready,
    output      logic [15:0] m_tdata,
    // Configuration write
    input  wire logic        cfg_valid,
    output      logic        cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [9:0]  cfg_data
);

    cfg_t                  cfg_reg;
    state_t                state_reg;
    state_t                state_next;
    logic [HOLD_WIDTH-1:0] hold_reg;
    logic [HOLD_WIDTH-1:0] hold_next;
    logic                  out_valid_reg;
    logic [15:0]           out_data_reg;
    logic                  s_fire;

    assign cfg_ready = 1'b1;
    assign s_tready  = !out_valid_reg || m_tready;
    assign s_fire    = s_tvalid && s_tready;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mcd_mode         <= RST_MCD_MODE;
            cfg_reg.led_common_anode <= RST_LED_COMMON_ANODE;
            cfg_reg.home_region      <= RST_HOME_REGION;
            cfg_reg.change_ticks     <= RST_CHANGE_TICKS;
            cfg_reg.fast_blink_ticks <= RST_FAST_BLINK_TICKS;
            cfg_reg.slow_blink_ticks <= RST_SLOW_BLINK_TICKS;
            cfg_reg.turn_limit       <= RST_TURN_LIMIT;
            cfg_reg.reset_ticks      <= RST_RESET_TICKS;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_MCD_MODE:         cfg_reg.mcd_mode         <= cfg_data[0];
                CFG_LED_COMMON_ANODE: cfg_reg.led_common_anode <= cfg_data[0];
                CFG_HOME_REGION:      cfg_reg.home_region      <= cfg_data[1:0];
                CFG_CHANGE_TICKS:     cfg_reg.change_ticks     <= cfg_data;
                CFG_FAST_BLINK_TICKS: cfg_reg.fast_blink_ticks <= cfg_data[7:0];
                CFG_SLOW_BLINK_TICKS: cfg_reg.slow_blink_ticks <= cfg_data[7:0];
                CFG_TURN_LIMIT:       cfg_reg.turn_limit       <= cfg_data[7:0];
                CFG_RESET_TICKS:      cfg_reg.reset_ticks      <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // One poll pass
    srs_step #(
        .HOLD_WIDTH (HOLD_WIDTH)
    ) u_step (
        .cfg         (cfg_reg),
        .st          (state_reg),
        .hold        (hold_reg),
        .tick        (s_tdata[0]),
        .button_edge (s_tdata[1]),
        .button_down (s_tdata[2]),
        .st_next     (state_next),
        .hold_next   (hold_next)
    );

    // Selector state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= STATE_RESET;
            hold_reg  <= '0;
        end
        else if (s_fire)
        begin
            state_reg <= state_next;
            hold_reg  <= hold_next;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s_fire)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
            out_data_reg <= {6'd0, state_next.region_now, state_next.pin_latch};
    end

`ifndef SYNTHESIS
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        s_fire |=> m_tvalid)
        else $error("accepted request produced no result");

    a_started: assert property (@(posedge clk) disable iff (!rst_n)
        s_fire |=> state_reg.started)
        else $error("start state not formed after first request");

    a_reset_released: assert property (@(posedge clk) disable iff (!rst_n)
        !state_reg.reset_active |-> state_reg.pin_latch[PB_RESET_N])
        else $error("console reset held low with no pulse active");

    a_region_valid: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.region_now != LED_NONE)
        else $error("region code out of range");
`endif

endmodule

`default_nettype wire

>>> test/switchless_region_selector_test.sv
// Self-checking stream testbench for the region selector: poll passes in, pin results out.
`timescale 1ns / 100ps

module switchless_region_selector_test;
    import srs_pkg::*;

    localparam int HOLD_BITS = 16;
    localparam int REG_COUNT = 8;

    typedef enum int { PLAN_ZERO, PLAN_MAX, PLAN_LOW, PLAN_RANDOM } plan_kind_t;

    // One poll pass, tick in bit 0
    typedef struct packed {
        logic down;
        logic btn_edge;
        logic tick;
    } poll_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'd0;   // [0] tick, [1] button_edge, [2] button_down
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;          // [7:0] pins led_red..reset_out_n, [9:8] current_region
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = CFG_MCD_MODE;
    logic [9:0]  cfg_data = 10'd0;

    switchless_region_selector #(.HOLD_WIDTH(HOLD_BITS)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    // Stimulus and checking bookkeeping
    poll_t      poll_queue[$];
    logic [9:0] pin_results[$];
    logic       quiet_run = 1'b0;
    int         phase_items = 0;
    int         mismatch_count = 0;
    logic [9:0] plan_regs [REG_COUNT];
    logic [2:0] reg_order [REG_COUNT] = '{CFG_MCD_MODE, CFG_LED_COMMON_ANODE,
        CFG_HOME_REGION, CFG_CHANGE_TICKS, CFG_FAST_BLINK_TICKS,
        CFG_SLOW_BLINK_TICKS, CFG_TURN_LIMIT, CFG_RESET_TICKS};
    string      pin_name [8] = '{"led_red", "led_green", "led_blue", "video_pin",
        "language_pin", "video_pin_n", "language_pin_n", "reset_out_n"};

    // Shadow copy of the configuration registers
    logic       set_mcd = RST_MCD_MODE;
    logic       set_lca = RST_LED_COMMON_ANODE;
    logic [1:0] set_home = RST_HOME_REGION;
    logic [9:0] set_change = RST_CHANGE_TICKS;
    logic [7:0] set_fast = RST_FAST_BLINK_TICKS;
    logic [7:0] set_slow = RST_SLOW_BLINK_TICKS;
    logic [7:0] set_turns = RST_TURN_LIMIT;
    logic [7:0] set_pulse_len = RST_RESET_TICKS;

    // Shadow selector state
    logic                 started_q = 1'b0;
    logic [1:0]           region_q = RST_HOME_REGION;
    logic                 edge_pend_q = 1'b0;
    logic                 press_q = 1'b0;
    logic                 showing_q = 1'b0;
    logic                 confirming_q = 1'b0;
    logic                 pulse_q = 1'b0;
    logic                 phase_q = 1'b0;
    logic [7:0]           turns_q = 8'd0;
    logic [7:0]           wait_q = 8'd0;
    logic [2:0]           debounce_q = 3'd0;
    logic [HOLD_BITS-1:0] hold_q = '0;
    logic [7:0]           pins_q = PIN_RESET_INIT;

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 40)
            $display("ERROR %0t ns: %s", $time, msg);
    endtask

    function automatic void store_setting(input logic [2:0] idx, input logic [9:0] v);
        case (idx)
            CFG_MCD_MODE:         set_mcd = v[0];
            CFG_LED_COMMON_ANODE: set_lca = v[0];
            CFG_HOME_REGION:      set_home = v[1:0];
            CFG_CHANGE_TICKS:     set_change = v;
            CFG_FAST_BLINK_TICKS: set_fast = v[7:0];
            CFG_SLOW_BLINK_TICKS: set_slow = v[7:0];
            CFG_TURN_LIMIT:       set_turns = v[7:0];
            default:              set_pulse_len = v[7:0];
        endcase
    endfunction

    // LED bits for one region, or all dark; polarity as configured now
    function automatic void light_led(input logic [1:0] code);
        logic [2:0] lit;
        case (code)
            REGION_JP: lit = 3'b001;
            REGION_EU: lit = 3'b010;
            REGION_US: lit = 3'b100;
            default:   lit = 3'b000;
        endcase
        pins_q[2:0] = set_lca ? ~lit : lit;
    endfunction

    // Region pins plus optional console reset pulse
    function automatic void drive_region();
        pins_q[PB_VIDEO]   = (region_q != REGION_EU);
        pins_q[PB_LANG]    = (region_q != REGION_JP);
        pins_q[PB_VIDEO_N] = (region_q == REGION_EU);
        pins_q[PB_LANG_N]  = (region_q == REGION_JP);
        if (set_mcd) begin
            pins_q[PB_RESET_N] = 1'b0;
            pulse_q = 1'b1;
            wait_q = set_pulse_len;
        end
    endfunction

    // Advance the shadow selector by one poll pass, return {region, pins}
    function automatic logic [9:0] poll_selector(input poll_t p);
        if (!started_q) begin
            region_q = (set_home > REGION_US) ? REGION_US : set_home;
            pins_q = PIN_RESET_INIT;
            pulse_q = 1'b0;
            wait_q = 8'd0;
            drive_region();
            light_led(region_q);
            started_q = 1'b1;
        end

        // debounce: edges wait until the counter is idle
        if (p.btn_edge)
            edge_pend_q = 1'b1;
        if (edge_pend_q && debounce_q == 3'd0) begin
            debounce_q = DEBOUNCE_TICKS;
            press_q = 1'b1;
            edge_pend_q = 1'b0;
        end

        if (p.tick) begin
            if (press_q && hold_q != '1)
                hold_q = hold_q + 1'b1;
            if (debounce_q != 3'd0)
                debounce_q = debounce_q - 3'd1;
            if (wait_q != 8'd0)
                wait_q = wait_q - 8'd1;
        end

        // press evaluation once debounced
        if (press_q && debounce_q == 3'd0) begin
            if (p.down) begin
                if (hold_q > set_change)
                    showing_q = 1'b1;
            end else begin
                press_q = 1'b0;
                if (hold_q > set_change) begin
                    turns_q = 8'd0;
                    showing_q = 1'b0;
                    confirming_q = 1'b1;
                end else begin
                    pulse_q = 1'b1;
                    wait_q = set_pulse_len;
                end
                hold_q = '0;
            end
        end

        // fast blink through the regions
        if (showing_q && wait_q == 8'd0) begin
            light_led(phase_q ? region_q : LED_NONE);
            if (turns_q > set_turns) begin
                case (region_q)
                    REGION_JP: region_q = REGION_EU;
                    REGION_EU: region_q = REGION_US;
                    default:   region_q = REGION_JP;
                endcase
                turns_q = 8'd0;
            end else begin
                turns_q = turns_q + 8'd1;
            end
            phase_q = !phase_q;
            wait_q = set_fast;
        end

        // slow blink, then apply
        if (confirming_q && wait_q == 8'd0) begin
            light_led(phase_q ? region_q : LED_NONE);
            if (turns_q > CONFIRM_LIMIT) begin
                turns_q = 8'd0;
                confirming_q = 1'b0;
                light_led(region_q);
                drive_region();
            end else begin
                turns_q = turns_q + 8'd1;
            end
            phase_q = !phase_q;
            wait_q = set_slow;
        end

        if (pulse_q) begin
            if (wait_q != 8'd0) begin
                pins_q[PB_RESET_N] = 1'b0;
            end else begin
                pins_q[PB_RESET_N] = 1'b1;
                pulse_q = 1'b0;
            end
        end

        return {region_q, pins_q};
    endfunction

    // Request driver: predicts on acceptance, then offers the next poll
    always @(posedge clk) begin
        if (rst_n) begin
            if (s_tvalid && s_tready)
                pin_results.push_back(poll_selector(poll_t'(s_tdata[2:0])));
            if (!s_tvalid || s_tready) begin
                if (poll_queue.size() != 0 && (quiet_run || $urandom_range(99) >= 13)) begin
                    s_tdata <= {5'd0, poll_queue.pop_front()};
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor with random back-pressure
    always @(posedge clk) begin
        logic [9:0] want;
        if (rst_n) begin
            if (m_tvalid && m_tready) begin
                if (pin_results.size() == 0) begin
                    report_mismatch($sformatf("result %h with no pending poll", m_tdata[9:0]));
                end else begin
                    want = pin_results.pop_front();
                    for (int b = 0; b < 8; b++)
                        if (m_tdata[b] !== want[b])
                            report_mismatch($sformatf("%s got %b want %b",
                                pin_name[b], m_tdata[b], want[b]));
                    if (m_tdata[9:8] !== want[9:8])
                        report_mismatch($sformatf("current_region got %0d want %0d",
                            m_tdata[9:8], want[9:8]));
                end
            end
            m_tready <= quiet_run || ($urandom_range(99) >= 13);
        end
    end

    // Write all registers from plan_regs, valid held high across the burst
    task automatic load_settings();
        int k;
        k = 0;
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= reg_order[0];
        cfg_data <= plan_regs[reg_order[0]];
        while (k < REG_COUNT) begin
            @(posedge clk);
            if (cfg_ready) begin
                store_setting(reg_order[k], plan_regs[reg_order[k]]);
                k++;
                if (k < REG_COUNT) begin
                    cfg_index <= reg_order[k];
                    cfg_data <= plan_regs[reg_order[k]];
                end else begin
                    cfg_valid <= 1'b0;
                end
            end
        end
    endtask

    // Wait until every poll is taken and every result checked
    task automatic drain();
        @(negedge clk);
        while (poll_queue.size() != 0 || s_tvalid || pin_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic queue_poll(input logic t, input logic e, input logic d);
        poll_queue.push_back(poll_t'({d, e, t}));
        phase_items++;
    endtask

    // Press, hold, release, then a few quiet passes; noisy adds bounce
    task automatic add_press(input int hold_len, input bit noisy);
        queue_poll(1'($urandom_range(1)), 1'b1, 1'b1);
        repeat (hold_len)
            queue_poll($urandom_range(9) < 8, noisy && $urandom_range(9) == 0,
                !(noisy && $urandom_range(19) == 0));
        queue_poll(1'($urandom_range(1)), 1'b1, 1'b0);
        repeat ($urandom_range(3) == 0 ? $urandom_range(20) : $urandom_range(6))
            queue_poll($urandom_range(9) < 8, 1'b0, 1'b0);
    endtask

    task automatic plan_phase(input plan_kind_t kind);
        case (kind)
            PLAN_ZERO: begin
                plan_regs[CFG_MCD_MODE] = 10'd0;
                plan_regs[CFG_LED_COMMON_ANODE] = 10'd1;
                plan_regs[CFG_HOME_REGION] = 10'(REGION_JP);
                plan_regs[CFG_CHANGE_TICKS] = 10'd0;
                plan_regs[CFG_FAST_BLINK_TICKS] = 10'd0;
                plan_regs[CFG_SLOW_BLINK_TICKS] = 10'd0;
                plan_regs[CFG_TURN_LIMIT] = 10'd0;
                plan_regs[CFG_RESET_TICKS] = 10'd0;
            end
            PLAN_MAX: begin
                plan_regs[CFG_MCD_MODE] = 10'd1;
                plan_regs[CFG_LED_COMMON_ANODE] = 10'd1;
                plan_regs[CFG_HOME_REGION] = 10'(REGION_US);
                plan_regs[CFG_CHANGE_TICKS] = 10'd1023;
                plan_regs[CFG_FAST_BLINK_TICKS] = 10'd255;
                plan_regs[CFG_SLOW_BLINK_TICKS] = 10'd255;
                plan_regs[CFG_TURN_LIMIT] = 10'd255;
                plan_regs[CFG_RESET_TICKS] = 10'd255;
            end
            PLAN_LOW: begin
                plan_regs[CFG_MCD_MODE] = 10'd0;
                plan_regs[CFG_LED_COMMON_ANODE] = 10'd0;
                plan_regs[CFG_HOME_REGION] = 10'(REGION_EU);
                plan_regs[CFG_CHANGE_TICKS] = 10'd1;
                plan_regs[CFG_FAST_BLINK_TICKS] = 10'd1;
                plan_regs[CFG_SLOW_BLINK_TICKS] = 10'd1;
                plan_regs[CFG_TURN_LIMIT] = 10'd0;
                plan_regs[CFG_RESET_TICKS] = 10'd1;
            end
            default: begin
                plan_regs[CFG_MCD_MODE] = 10'($urandom_range(1));
                plan_regs[CFG_LED_COMMON_ANODE] = 10'($urandom_range(1));
                plan_regs[CFG_HOME_REGION] = 10'($urandom_range(3));
                plan_regs[CFG_CHANGE_TICKS] = 10'($urandom_range(1, 12));
                plan_regs[CFG_FAST_BLINK_TICKS] = 10'($urandom_range(4));
                plan_regs[CFG_SLOW_BLINK_TICKS] = 10'($urandom_range(4));
                plan_regs[CFG_TURN_LIMIT] =
                    10'(($urandom_range(7) == 0) ? 255 : $urandom_range(3));
                plan_regs[CFG_RESET_TICKS] = 10'($urandom_range(1, 8));
            end
        endcase
    endtask

    // Random phase: mostly clean presses, some bouncy presses and noise
    task automatic fill_phase();
        int hold_limit;
        int pick;
        phase_items = 0;
        hold_limit = (set_change > 40) ? 20 : set_change + 30;
        while (phase_items < 46) begin
            pick = $urandom_range(99);
            if (pick < 70)
                add_press($urandom_range(hold_limit), 1'b0);
            else if (pick < 85)
                add_press($urandom_range(hold_limit), 1'b1);
            else
                repeat ($urandom_range(1, 4))
                    queue_poll(1'($urandom_range(1)), 1'($urandom_range(1)),
                        1'($urandom_range(1)));
        end
    endtask

    // Main sequence
    initial begin
        plan_kind_t kind;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // start state taken from these: home region code three (clamped to US), reset pulse at start
        plan_regs[CFG_MCD_MODE] = 10'd1;
        plan_regs[CFG_LED_COMMON_ANODE] = 10'd0;
        plan_regs[CFG_HOME_REGION] = 10'd3;
        plan_regs[CFG_CHANGE_TICKS] = 10'd3;
        plan_regs[CFG_FAST_BLINK_TICKS] = 10'd2;
        plan_regs[CFG_SLOW_BLINK_TICKS] = 10'd1;
        plan_regs[CFG_TURN_LIMIT] = 10'd1;
        plan_regs[CFG_RESET_TICKS] = 10'd4;
        load_settings();

        // directed: start-up pulse, bounce-only release, pending edge, long hold
        @(negedge clk);
        queue_poll(1'b0, 1'b0, 1'b0);
        repeat (3) queue_poll(1'b1, 1'b0, 1'b0);
        queue_poll(1'b0, 1'b1, 1'b0);
        queue_poll(1'b1, 1'b1, 1'b0);
        repeat (5) queue_poll(1'b1, 1'b0, 1'b0);
        queue_poll(1'b1, 1'b1, 1'b1);
        repeat (10) queue_poll(1'b1, 1'b0, 1'b1);
        queue_poll(1'b1, 1'b1, 1'b0);
        repeat (3) queue_poll(1'b1, 1'b0, 1'b0);
        drain();

        for (int p = 0; p < 9; p++) begin
            case (p)
                0:       kind = PLAN_ZERO;
                1:       kind = PLAN_MAX;
                2:       kind = PLAN_LOW;
                default: kind = PLAN_RANDOM;
            endcase
            plan_phase(kind);
            load_settings();
            @(negedge clk);
            quiet_run = (p == 3 || p == 4);
            fill_phase();
            drain();
            quiet_run = 1'b0;
        end

        if (pin_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pin_results.size()));
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Watchdog
    initial begin
        #400000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
